// ===== src/plv_pkg.sv =====
// package: item types, field widths and result kind codes for the position list decoder
package plv_pkg;

    localparam int MASK_W  = 32;
    localparam int POS_W   = 32;
    localparam int FREQ_W  = 32;
    localparam int COUNT_W = 6;
    localparam int ACC_W   = 64;
    localparam int GROUP_W = 7;
    localparam int GC_W    = 4;

    localparam logic [1:0] KIND_POS = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [7:0] END_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       list_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [POS_W-1:0]   position;
        logic [MASK_W-1:0]  active_mask;
        logic [COUNT_W-1:0] field_count;
        logic [FREQ_W-1:0]  term_frequency;
    } out_item_t;

endpackage

// ===== src/plv_in_stage.sv =====
// input register stage holding one accepted byte item
module plv_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  plv_pkg::in_item_t item,
    input  logic              advance,
    output logic              held_valid,
    output plv_pkg::in_item_t held_item
);
    import plv_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign item_ready = !valid_reg || advance;
    assign valid_next = item_ready ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== src/plv_decode.sv =====
// varint assembly, delta and mask decode with running position and frequency state
module plv_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  plv_pkg::in_item_t  item,
    output logic               res_valid,
    output plv_pkg::out_item_t res
);
    import plv_pkg::*;

    function automatic logic [COUNT_W-1:0] ones_in(input logic [MASK_W-1:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            n = n + COUNT_W'(v[i]);
        end
        return n;
    endfunction

    logic [ACC_W-1:0]   acc_reg,   acc_next;
    logic [GC_W-1:0]    gc_reg,    gc_next;
    logic               pend_reg,  pend_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [MASK_W-1:0]  mask_reg,  mask_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FREQ_W-1:0]  freq_reg,  freq_next;
    logic               done_reg,  done_next;

    logic [ACC_W-1:0]   acc_cur;
    logic [GC_W-1:0]    gc_cur;
    logic               pend_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [MASK_W-1:0]  mask_cur;
    logic [COUNT_W-1:0] count_cur;
    logic [FREQ_W-1:0]  freq_cur;
    logic               done_cur;
    logic [ACC_W-1:0]   acc_shift;
    logic [FREQ_W:0]    freq_sum;
    logic               emit;
    logic [1:0]         kind;

    always_comb
    begin
        acc_cur   = item.list_start ? '0 : acc_reg;
        gc_cur    = item.list_start ? '0 : gc_reg;
        pend_cur  = item.list_start ? 1'b0 : pend_reg;
        pos_cur   = item.list_start ? '0 : pos_reg;
        mask_cur  = item.list_start ? MASK_W'(1) : mask_reg;
        count_cur = item.list_start ? COUNT_W'(1) : count_reg;
        freq_cur  = item.list_start ? '0 : freq_reg;
        done_cur  = item.list_start ? 1'b0 : done_reg;

        acc_shift = {acc_cur[ACC_W-GROUP_W-1:0], item.data_byte[GROUP_W-1:0]};
        freq_sum  = {1'b0, freq_cur} + (FREQ_W+1)'(count_cur);

        acc_next   = acc_cur;
        gc_next    = gc_cur;
        pend_next  = pend_cur;
        pos_next   = pos_cur;
        mask_next  = mask_cur;
        count_next = count_cur;
        freq_next  = freq_cur;
        done_next  = done_cur;
        emit       = 1'b0;
        kind       = KIND_ERR;

        if (done_cur)
        begin
            emit = 1'b1;
        end
        else if (gc_cur == '0 && item.data_byte == END_BYTE)
        begin
            emit      = 1'b1;
            done_next = 1'b1;
            kind      = pend_cur ? KIND_ERR : KIND_END;
        end
        else if (acc_cur[ACC_W-1:ACC_W-GROUP_W] != '0)
        begin
            emit      = 1'b1;
            done_next = 1'b1;
        end
        else if (item.data_byte[7])
        begin
            acc_next = acc_shift;
            gc_next  = (gc_cur == '1) ? gc_cur : gc_cur + GC_W'(1);
        end
        else if (!acc_shift[0])
        begin
            if (pend_cur || acc_shift[ACC_W-1:MASK_W+1] != '0)
            begin
                emit      = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                mask_next  = acc_shift[MASK_W:1];
                count_next = ones_in(acc_shift[MASK_W:1]);
                pend_next  = 1'b1;
                acc_next   = '0;
                gc_next    = '0;
            end
        end
        else if (acc_shift[ACC_W-1:POS_W+1] != '0)
        begin
            emit      = 1'b1;
            done_next = 1'b1;
        end
        else
        begin
            emit      = 1'b1;
            kind      = KIND_POS;
            acc_next  = '0;
            gc_next   = '0;
            pend_next = 1'b0;
            pos_next  = pos_cur + acc_shift[POS_W:1];
            freq_next = freq_sum[FREQ_W] ? '1 : freq_sum[FREQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            gc_reg    <= '0;
            pend_reg  <= 1'b0;
            pos_reg   <= '0;
            mask_reg  <= MASK_W'(1);
            count_reg <= COUNT_W'(1);
            freq_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (step)
        begin
            acc_reg   <= acc_next;
            gc_reg    <= gc_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            mask_reg  <= mask_next;
            count_reg <= count_next;
            freq_reg  <= freq_next;
            done_reg  <= done_next;
        end
    end

    assign res_valid          = step && emit;
    assign res.kind           = kind;
    assign res.position       = pos_next;
    assign res.active_mask    = mask_next;
    assign res.field_count    = count_next;
    assign res.term_frequency = freq_next;

endmodule

// ===== src/plv_out_stage.sv =====
// result register stage holding one result item until taken
module plv_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  plv_pkg::out_item_t res,
    output logic               free,
    output logic               result_valid,
    input  logic               result_ready,
    output plv_pkg::out_item_t result
);
    import plv_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t result_reg;

    assign free       = !valid_reg || result_ready;
    assign valid_next = free ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== src/position_list_varint_decoder_top.sv =====
// top level of the position list varint decoder
// a byte held in the input register is decoded into the result register when that is free
// throughput: one byte per cycle while result_ready keeps the result register free;
// continuation bytes and mask ends give no item; a byte is decoded when the result
// register is empty or being emptied; reset clears position, frequency and partial
// value, sets the mask to one and leaves both stages empty
module position_list_varint_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  plv_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output plv_pkg::out_item_t result
);
    import plv_pkg::*;

    logic      held_valid;
    in_item_t  held_item;
    logic      free;
    logic      advance;
    logic      res_valid;
    out_item_t res;

    assign advance = held_valid && free;

    plv_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    plv_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    plv_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .free         (free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
